// ===== rtl/fdl_pkg.sv =====
// Shared constants, types and helpers for the fractional delay line.
// Every rtl file refers to this package by scoped names.
package fdl_pkg;

  localparam int FIR_TAPS    = 32;
  localparam int DELAY_DEPTH = 65536;

  localparam int TAP_W   = $clog2(FIR_TAPS);
  localparam int ADDR_W  = $clog2(DELAY_DEPTH);
  localparam int SMP_W   = 24;
  localparam int COEF_W  = 18;
  localparam int TIDX_W  = 5;
  localparam int FRAC_W  = 16;
  localparam int K_W     = 32;
  localparam int DT_W    = 16;
  localparam int RP_W    = ADDR_W + FRAC_W;
  localparam int DN_W    = ADDR_W + K_W;
  localparam int ACC_W   = 48;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [DT_W-1:0] DT_RESET = DT_W'(250);
  localparam logic [K_W-1:0]  K_RESET  = K_W'(42950);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(2 ** (SMP_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO     = -SAT_HI - ACC_W'(1);
  localparam logic [RP_W:0]           DEPTH_FX   = (RP_W + 1)'(DELAY_DEPTH) << FRAC_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GLO,
    S_GHI,
    S_MAC,
    S_FIR,
    S_WR,
    S_RD0,
    S_RD1,
    S_DIF,
    S_IMUL,
    S_IRES,
    S_POS
  } state_e;

  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_GLO,
    TAG_GHI,
    TAG_MAC,
    TAG_INTERP
  } mul_tag_e;

  typedef enum logic {
    REG_DELAY_TARGET = 1'b0,
    REG_GLIDE_COEF   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [SMP_W-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic              we;
    logic [TAP_W-1:0]  idx;
    logic [COEF_W-1:0] val;
  } tap_wr_t;

  typedef struct packed {
    logic             we;
    logic [TAP_W-1:0] idx;
    logic [SMP_W-1:0] val;
  } ring_wr_t;

  function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > SAT_HI) begin
      r = SMP_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = SMP_W'(SAT_LO);
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/fdl_mul.sv =====
// Shared signed multiplier with a registered product and a tag that names its use.
// Depends on fdl_pkg for widths and the tag type.
module fdl_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [fdl_pkg::MUL_W-1:0]    a_i,
  input  logic signed [fdl_pkg::MUL_W-1:0]    b_i,
  input  fdl_pkg::mul_tag_e                   tag_i,
  output logic signed [fdl_pkg::PROD_W-1:0]   prod_o,
  output fdl_pkg::mul_tag_e                   tag_o
);

  logic signed [fdl_pkg::PROD_W-1:0] prod_q;
  fdl_pkg::mul_tag_e                 tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= fdl_pkg::TAG_NONE;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;
  assign tag_o  = tag_q;

endmodule

// ===== rtl/fdl_fir_regs.sv =====
// Coefficient store and sample ring of the FIR pre-filter, one read port each.
// Depends on fdl_pkg for sizes and write structs.
module fdl_fir_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fdl_pkg::tap_wr_t                   tap_wr_i,
  input  fdl_pkg::ring_wr_t                  ring_wr_i,
  input  logic [fdl_pkg::TAP_W-1:0]          tap_idx_i,
  input  logic [fdl_pkg::TAP_W-1:0]          ring_idx_i,
  output logic signed [fdl_pkg::COEF_W-1:0]  tap_o,
  output logic signed [fdl_pkg::SMP_W-1:0]   smp_o
);

  logic signed [fdl_pkg::COEF_W-1:0] taps_q [fdl_pkg::FIR_TAPS];
  logic signed [fdl_pkg::SMP_W-1:0]  ring_q [fdl_pkg::FIR_TAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fdl_pkg::FIR_TAPS; i++) begin
        taps_q[i] <= '0;
        ring_q[i] <= '0;
      end
    end else begin
      if (tap_wr_i.we) begin
        taps_q[tap_wr_i.idx] <= tap_wr_i.val;
      end
      if (ring_wr_i.we) begin
        ring_q[ring_wr_i.idx] <= ring_wr_i.val;
      end
    end
  end

  assign tap_o = taps_q[tap_idx_i];
  assign smp_o = ring_q[ring_idx_i];

endmodule

// ===== rtl/fdl_dly_mem.sv =====
// Delay store: one write port and one registered read port.
// Depends on fdl_pkg for depth, widths and the write struct.
module fdl_dly_mem (
  input  logic                          clk_i,
  input  fdl_pkg::mem_wr_t              wr_i,
  input  logic [fdl_pkg::ADDR_W-1:0]    raddr_i,
  output logic [fdl_pkg::SMP_W-1:0]     rdata_o
);

  logic [fdl_pkg::SMP_W-1:0] mem_q [fdl_pkg::DELAY_DEPTH];
  logic [fdl_pkg::SMP_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fir_fractional_delay_line.sv =====
// Fractional delay line: glide, FIR pre-filter, delay store, linear interpolation.
// Samples are handled one at a time: a new sample beat is stalled until the previous result
// is taken into the output register, since the FIR taps and glide and interpolation products
// all pass through one shared multiplier; a coefficient beat is taken while idle.
// Reset clears taps, ring, positions and delay; the delay store reads as zero until written,
// tracked by write position and a wrap flag, so no clearing pass is needed.
module fir_fractional_delay_line (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic signed [fdl_pkg::SMP_W-1:0]   sample_in_i,
  input  logic [fdl_pkg::TIDX_W-1:0]         tap_index_i,
  input  logic signed [fdl_pkg::COEF_W-1:0]  tap_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [fdl_pkg::SMP_W-1:0]   sample_out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fdl_pkg::PADDR_W-1:0]        paddr,
  input  logic [fdl_pkg::PDATA_W-1:0]        pwdata,
  output logic [fdl_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  fdl_pkg::state_e state_q, state_d;

  logic [fdl_pkg::DT_W-1:0] dtgt_q;
  logic [fdl_pkg::K_W-1:0]  kcoef_q;

  logic [fdl_pkg::DN_W-1:0]   delay_now_q;
  logic [fdl_pkg::RP_W-1:0]   read_pos_q;
  logic [fdl_pkg::ADDR_W-1:0] write_pos_q;
  logic                       filled_q;
  logic [fdl_pkg::TAP_W-1:0]  filter_pos_q;
  logic                       upd_pend_q;
  logic [fdl_pkg::TAP_W-1:0]  tcnt_q;
  logic [fdl_pkg::TAP_W-1:0]  rptr_q;

  logic [fdl_pkg::DN_W-1:0]          gap_q;
  logic                              gap_neg_q;
  logic [fdl_pkg::K_W-1:0]           step_lo_q;
  logic [fdl_pkg::DN_W-1:0]          step_q;
  logic signed [fdl_pkg::ACC_W-1:0]  acc_q;
  logic signed [fdl_pkg::SMP_W-1:0]  s0_q;
  logic                              rd_ok_q;
  logic signed [fdl_pkg::ACC_W-1:0]  base_q;
  logic signed [fdl_pkg::SMP_W:0]    diff_q;
  logic signed [fdl_pkg::SMP_W-1:0]  y_q;
  logic [fdl_pkg::RP_W:0]            rp_raw_q;

  logic                              out_valid_q;
  logic signed [fdl_pkg::SMP_W-1:0]  sample_out_q;

  logic in_acc, smp_acc, cfg_wr, out_free;

  logic [fdl_pkg::ADDR_W-1:0] tgt_clamp;
  logic [fdl_pkg::DN_W-1:0]   tgt_fx;
  logic [fdl_pkg::ADDR_W-1:0] rd_idx, rd_nxt;
  logic [fdl_pkg::RP_W-1:0]   dly_off;

  logic signed [fdl_pkg::MUL_W-1:0]  mul_a, mul_b;
  fdl_pkg::mul_tag_e                 mul_tag, prod_tag;
  logic signed [fdl_pkg::PROD_W-1:0] prod;

  fdl_pkg::mem_wr_t                  mem_wr;
  logic [fdl_pkg::ADDR_W-1:0]        mem_raddr;
  logic [fdl_pkg::SMP_W-1:0]         mem_rdata;
  logic signed [fdl_pkg::SMP_W-1:0]  rd_val;

  fdl_pkg::tap_wr_t                  tap_wr;
  fdl_pkg::ring_wr_t                 ring_wr;
  logic signed [fdl_pkg::COEF_W-1:0] tap_rd;
  logic signed [fdl_pkg::SMP_W-1:0]  ring_rd;

  logic signed [fdl_pkg::ACC_W-1:0]  interp_sum;

  assign in_stall_o   = (state_q != fdl_pkg::S_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign smp_acc      = in_acc && !kind_i;
  assign cfg_wr       = psel && penable && pwrite && pready;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign pready       = 1'b1;

  // ---------------- configuration port ----------------
  always_comb begin
    unique case (fdl_pkg::reg_idx_e'(paddr[2]))
      fdl_pkg::REG_DELAY_TARGET: prdata = fdl_pkg::PDATA_W'(dtgt_q);
      fdl_pkg::REG_GLIDE_COEF:   prdata = fdl_pkg::PDATA_W'(kcoef_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dtgt_q  <= fdl_pkg::DT_RESET;
      kcoef_q <= fdl_pkg::K_RESET;
    end else if (cfg_wr) begin
      unique case (fdl_pkg::reg_idx_e'(paddr[2]))
        fdl_pkg::REG_DELAY_TARGET: dtgt_q  <= pwdata[fdl_pkg::DT_W-1:0];
        fdl_pkg::REG_GLIDE_COEF:   kcoef_q <= pwdata[fdl_pkg::K_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- address and target helpers ----------------
  always_comb begin
    if (32'(dtgt_q) > 32'(fdl_pkg::DELAY_DEPTH - 1)) begin
      tgt_clamp = fdl_pkg::ADDR_W'(fdl_pkg::DELAY_DEPTH - 1);
    end else begin
      tgt_clamp = fdl_pkg::ADDR_W'(dtgt_q);
    end
  end

  assign tgt_fx  = {tgt_clamp, {fdl_pkg::K_W{1'b0}}};
  assign rd_idx  = read_pos_q[fdl_pkg::RP_W-1:fdl_pkg::FRAC_W];
  assign rd_nxt  = (rd_idx == fdl_pkg::ADDR_W'(fdl_pkg::DELAY_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
  assign dly_off = delay_now_q[fdl_pkg::DN_W-1:fdl_pkg::FRAC_W];
  assign rd_val  = rd_ok_q ? $signed(mem_rdata) : '0;

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fdl_pkg::S_IDLE: if (smp_acc) state_d = fdl_pkg::S_GLO;
      fdl_pkg::S_GLO:  state_d = fdl_pkg::S_GHI;
      fdl_pkg::S_GHI:  state_d = fdl_pkg::S_MAC;
      fdl_pkg::S_MAC: begin
        if (tcnt_q == fdl_pkg::TAP_W'(fdl_pkg::FIR_TAPS - 1)) state_d = fdl_pkg::S_FIR;
      end
      fdl_pkg::S_FIR:  state_d = fdl_pkg::S_WR;
      fdl_pkg::S_WR:   state_d = fdl_pkg::S_RD0;
      fdl_pkg::S_RD0:  state_d = fdl_pkg::S_RD1;
      fdl_pkg::S_RD1:  state_d = fdl_pkg::S_DIF;
      fdl_pkg::S_DIF:  state_d = fdl_pkg::S_IMUL;
      fdl_pkg::S_IMUL: state_d = fdl_pkg::S_IRES;
      fdl_pkg::S_IRES: state_d = fdl_pkg::S_POS;
      fdl_pkg::S_POS:  if (out_free) state_d = fdl_pkg::S_IDLE;
      default:         state_d = fdl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    mul_tag      = fdl_pkg::TAG_NONE;
    mem_wr.we    = 1'b0;
    mem_wr.addr  = write_pos_q;
    mem_wr.data  = fdl_pkg::sat_smp(acc_q >>> fdl_pkg::FRAC_W);
    mem_raddr    = rd_idx;
    tap_wr.we    = 1'b0;
    tap_wr.idx   = fdl_pkg::TAP_W'(tap_index_i);
    tap_wr.val   = tap_value_i;
    ring_wr.we   = 1'b0;
    ring_wr.idx  = filter_pos_q;
    ring_wr.val  = sample_in_i;
    unique case (state_q)
      fdl_pkg::S_IDLE: begin
        tap_wr.we  = in_acc && kind_i && (32'(tap_index_i) < 32'(fdl_pkg::FIR_TAPS));
        ring_wr.we = smp_acc;
      end
      fdl_pkg::S_GLO: begin
        mul_a   = fdl_pkg::MUL_W'(gap_q[fdl_pkg::K_W-1:0]);
        mul_b   = fdl_pkg::MUL_W'(kcoef_q);
        mul_tag = fdl_pkg::TAG_GLO;
      end
      fdl_pkg::S_GHI: begin
        mul_a   = fdl_pkg::MUL_W'(gap_q[fdl_pkg::DN_W-1:fdl_pkg::K_W]);
        mul_b   = fdl_pkg::MUL_W'(kcoef_q);
        mul_tag = fdl_pkg::TAG_GHI;
      end
      fdl_pkg::S_MAC: begin
        mul_a   = fdl_pkg::MUL_W'(ring_rd);
        mul_b   = fdl_pkg::MUL_W'(tap_rd);
        mul_tag = fdl_pkg::TAG_MAC;
      end
      fdl_pkg::S_WR:  mem_wr.we = 1'b1;
      fdl_pkg::S_RD0: mem_raddr = rd_idx;
      fdl_pkg::S_RD1: mem_raddr = rd_nxt;
      fdl_pkg::S_IMUL: begin
        mul_a   = fdl_pkg::MUL_W'(read_pos_q[fdl_pkg::FRAC_W-1:0]);
        mul_b   = fdl_pkg::MUL_W'(diff_q);
        mul_tag = fdl_pkg::TAG_INTERP;
      end
      default: ;
    endcase
  end

  // ---------------- model state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_now_q  <= '0;
      upd_pend_q   <= 1'b0;
      read_pos_q   <= '0;
      write_pos_q  <= '0;
      filled_q     <= 1'b0;
      filter_pos_q <= '0;
      tcnt_q       <= '0;
      rptr_q       <= '0;
    end else begin
      // the glide step is applied in the cycle after its sum is formed
      upd_pend_q <= (prod_tag == fdl_pkg::TAG_GHI);
      if (upd_pend_q) begin
        delay_now_q <= gap_neg_q ? delay_now_q - step_q : delay_now_q + step_q;
      end
      if (smp_acc) begin
        tcnt_q <= '0;
        rptr_q <= filter_pos_q;
      end else if (state_q == fdl_pkg::S_MAC) begin
        tcnt_q <= tcnt_q + 1'b1;
        rptr_q <= (rptr_q == '0) ? fdl_pkg::TAP_W'(fdl_pkg::FIR_TAPS - 1) : rptr_q - 1'b1;
      end
      if (state_q == fdl_pkg::S_WR) begin
        filter_pos_q <= (filter_pos_q == fdl_pkg::TAP_W'(fdl_pkg::FIR_TAPS - 1)) ? '0 :
                        filter_pos_q + 1'b1;
      end
      if (state_q == fdl_pkg::S_IMUL) begin
        if (write_pos_q == fdl_pkg::ADDR_W'(fdl_pkg::DELAY_DEPTH - 1)) begin
          write_pos_q <= '0;
          filled_q    <= 1'b1;
        end else begin
          write_pos_q <= write_pos_q + 1'b1;
        end
      end
      if (state_q == fdl_pkg::S_POS && out_free) begin
        read_pos_q <= rp_raw_q[fdl_pkg::RP_W] ?
                      fdl_pkg::RP_W'(rp_raw_q + fdl_pkg::DEPTH_FX) :
                      rp_raw_q[fdl_pkg::RP_W-1:0];
      end
    end
  end

  // ---------------- working registers ----------------
  assign interp_sum = $signed(prod[fdl_pkg::ACC_W-1:0]) + base_q;

  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      gap_neg_q <= (tgt_fx < delay_now_q);
      gap_q     <= (tgt_fx < delay_now_q) ? delay_now_q - tgt_fx : tgt_fx - delay_now_q;
      acc_q     <= fdl_pkg::ROUND_HALF;
    end
    case (prod_tag)
      fdl_pkg::TAG_GLO:    step_lo_q <= prod[2*fdl_pkg::K_W-1:fdl_pkg::K_W];
      fdl_pkg::TAG_GHI:    step_q <= prod[fdl_pkg::DN_W-1:0] + fdl_pkg::DN_W'(step_lo_q);
      fdl_pkg::TAG_MAC:    acc_q <= acc_q + $signed(prod[fdl_pkg::ACC_W-1:0]);
      fdl_pkg::TAG_INTERP: y_q <= fdl_pkg::sat_smp(interp_sum >>> fdl_pkg::FRAC_W);
      default: ;
    endcase
    if (state_q == fdl_pkg::S_RD0) begin
      rd_ok_q <= filled_q || (rd_idx <= write_pos_q);
    end
    if (state_q == fdl_pkg::S_RD1) begin
      s0_q    <= rd_val;
      rd_ok_q <= filled_q || (rd_nxt <= write_pos_q);
    end
    if (state_q == fdl_pkg::S_DIF) begin
      diff_q <= (fdl_pkg::SMP_W + 1)'(rd_val) - (fdl_pkg::SMP_W + 1)'(s0_q);
      // fold the sample and the rounding half into one addend
      base_q <= (fdl_pkg::ACC_W'(s0_q) <<< fdl_pkg::FRAC_W) | fdl_pkg::ROUND_HALF;
    end
    if (state_q == fdl_pkg::S_IRES) begin
      rp_raw_q <= {1'b0, write_pos_q, {fdl_pkg::FRAC_W{1'b0}}} - {1'b0, dly_off};
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == fdl_pkg::S_POS && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fdl_pkg::S_POS && out_free) begin
      sample_out_q <= y_q;
    end
  end

  // ---------------- submodules ----------------
  fdl_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .tag_i  (mul_tag),
    .prod_o (prod),
    .tag_o  (prod_tag)
  );

  fdl_fir_regs u_fir_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tap_wr_i   (tap_wr),
    .ring_wr_i  (ring_wr),
    .tap_idx_i  (tcnt_q),
    .ring_idx_i (rptr_q),
    .tap_o      (tap_rd),
    .smp_o      (ring_rd)
  );

  fdl_dly_mem u_dly_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------- assertions ----------------
  a_read_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(read_pos_q[fdl_pkg::RP_W-1:fdl_pkg::FRAC_W]) < 32'(fdl_pkg::DELAY_DEPTH))
    else $error("read position beyond delay store");

  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(delay_now_q[fdl_pkg::DN_W-1:fdl_pkg::K_W]) <= 32'(fdl_pkg::DELAY_DEPTH - 1))
    else $error("glided delay passed the clamped target");

  a_mac_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_tag == fdl_pkg::TAG_MAC) |-> (state_q == fdl_pkg::S_MAC || state_q == fdl_pkg::S_FIR))
    else $error("tap product outside the accumulate window");

  a_glide_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_pend_q |-> (state_q == fdl_pkg::S_MAC))
    else $error("delay update outside the tap loop");

  a_result_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fdl_pkg::S_POS && out_free) |=> (out_valid_o && state_q == fdl_pkg::S_IDLE))
    else $error("finished sample not presented");

endmodule
